### src/bmh_pkg.sv
// bmh_pkg: shared constants, codes and types of the binary max-heap priority queue
`timescale 1ns / 1ps
`default_nettype none
package bmh_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CH_W       = ADDR_W + 1;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 11;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_POP   = 2'd1,
        K_EMPTY = 2'd2,
        K_FULL  = 2'd3
    } t_kind;

    // one classified command waiting for the heap engine
    typedef struct packed {
        t_kind                      kind;
        logic signed [VALUE_W-1:0]  value;
        logic [CNT_W-1:0]           count;
    } t_job;

endpackage
`default_nettype wire

### src/bmh_if.sv
// bmh_if: command and response channel interfaces of the heap
`timescale 1ns / 1ps
`default_nettype none
interface bmh_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [bmh_pkg::VALUE_W-1:0] value;

    modport source(output valid, output command, output value, input ready);
    modport sink(input valid, input command, input value, output ready);
endinterface

interface bmh_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bmh_pkg::VALUE_W-1:0]  popped_value;
    logic [bmh_pkg::STATUS_W-1:0]        status;
    logic [bmh_pkg::ENTRY_W-1:0]         entry_count;

    modport source(output valid, output popped_value, output status, output entry_count,
                   input ready);
    modport sink(input valid, input popped_value, input status, input entry_count,
                 output ready);
endinterface
`default_nettype wire

### src/bmh_front.sv
// bmh_front: accepts commands, checks full/empty against the running count and classifies them
`timescale 1ns / 1ps
`default_nettype none
module bmh_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bmh_cmd_if.sink            i_cmd,
    output bmh_pkg::t_job      o_job,
    output logic               o_job_valid,
    input  wire logic          i_job_ready
);

    logic [bmh_pkg::CNT_W-1:0] r_count;
    logic [bmh_pkg::CNT_W-1:0] n_count;
    logic                      w_xfer;

    assign i_cmd.ready = i_job_ready;
    assign o_job_valid = i_cmd.valid;
    assign w_xfer      = i_cmd.valid && i_job_ready;

    // count is tracked here so each command is classified as it arrives
    always_comb begin
        n_count     = r_count;
        o_job.value = i_cmd.value;
        o_job.kind  = bmh_pkg::K_PUSH;
        if (i_cmd.command == bmh_pkg::CMD_POP) begin
            if (r_count == '0) begin
                o_job.kind = bmh_pkg::K_EMPTY;
            end else begin
                o_job.kind = bmh_pkg::K_POP;
                n_count    = r_count - bmh_pkg::CNT_W'(1);
            end
        end else begin
            if (r_count == bmh_pkg::CNT_W'(bmh_pkg::HEAP_DEPTH)) begin
                o_job.kind = bmh_pkg::K_FULL;
            end else begin
                o_job.kind = bmh_pkg::K_PUSH;
                n_count    = r_count + bmh_pkg::CNT_W'(1);
            end
        end
        o_job.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_xfer) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### src/bmh_queue.sv
// bmh_queue: two-entry job queue between the classifier and the heap engine
`timescale 1ns / 1ps
`default_nettype none
module bmh_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bmh_pkg::t_job i_job,
    input  wire logic          i_valid,
    output logic               o_ready,
    output bmh_pkg::t_job      o_job,
    output logic               o_valid,
    input  wire logic          i_ready
);

    bmh_pkg::t_job r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/bmh_back.sv
// bmh_back: heap engine with the entry memory, sift-up/sift-down sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module bmh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bmh_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    bmh_rsp_if.source          o_rsp
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP_RD  = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_POP_RD = 8'b0000_1000,
        S_POP_LD = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                               r_state;
    t_state                               n_state;
    logic signed [bmh_pkg::VALUE_W-1:0]   r_v;
    logic signed [bmh_pkg::VALUE_W-1:0]   n_v;
    logic [bmh_pkg::ADDR_W-1:0]           r_pos;
    logic [bmh_pkg::ADDR_W-1:0]           n_pos;
    logic [bmh_pkg::CNT_W-1:0]            r_n;
    logic [bmh_pkg::CNT_W-1:0]            n_n;
    logic signed [bmh_pkg::VALUE_W-1:0]   r_pop;
    logic signed [bmh_pkg::VALUE_W-1:0]   n_pop;
    logic [bmh_pkg::STATUS_W-1:0]         r_status;
    logic [bmh_pkg::STATUS_W-1:0]         n_status;

    logic signed [bmh_pkg::VALUE_W-1:0]   r_mem [bmh_pkg::HEAP_DEPTH];
    logic signed [bmh_pkg::VALUE_W-1:0]   r_rd0;
    logic signed [bmh_pkg::VALUE_W-1:0]   r_rd1;
    logic                                 w_we;
    logic [bmh_pkg::ADDR_W-1:0]           w_wa;
    logic signed [bmh_pkg::VALUE_W-1:0]   w_wd;
    logic [bmh_pkg::ADDR_W-1:0]           w_ra0;
    logic [bmh_pkg::ADDR_W-1:0]           w_ra1;

    logic [bmh_pkg::ADDR_W-1:0]           w_parent;
    logic [bmh_pkg::CH_W-1:0]             w_lc;
    logic [bmh_pkg::CH_W-1:0]             w_rc;
    logic [bmh_pkg::CH_W-1:0]             w_n_ch;
    logic                                 w_l_gt;
    logic                                 w_r_gt;
    logic signed [bmh_pkg::VALUE_W-1:0]   w_best;
    logic                                 w_load;

    logic                                 r_out_valid;
    logic signed [bmh_pkg::VALUE_W-1:0]   r_out_pop;
    logic [bmh_pkg::STATUS_W-1:0]         r_out_status;
    logic [bmh_pkg::ENTRY_W-1:0]          r_out_count;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_out_pop;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;

    assign o_job_ready = (r_state == S_IDLE);
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_parent = (r_pos - bmh_pkg::ADDR_W'(1)) >> 1;
    assign w_lc     = (bmh_pkg::CH_W'(r_pos) << 1) + bmh_pkg::CH_W'(1);
    assign w_rc     = (bmh_pkg::CH_W'(r_pos) << 1) + bmh_pkg::CH_W'(2);
    assign w_n_ch   = bmh_pkg::CH_W'(r_n);

    // left child wins ties: right must be strictly above the best so far
    assign w_l_gt = (r_rd0 > r_v);
    assign w_best = w_l_gt ? r_rd0 : r_v;
    assign w_r_gt = (w_rc < w_n_ch) && (r_rd1 > w_best);

    // moving value stays in r_v; each level writes the displaced entry into the hole
    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_pos    = r_pos;
        n_n      = r_n;
        n_pop    = r_pop;
        n_status = r_status;
        w_we     = 1'b0;
        w_wa     = r_pos;
        w_wd     = r_v;
        w_ra0    = w_parent;
        w_ra1    = r_n[bmh_pkg::ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_v      = i_job.value;
                    n_n      = i_job.count;
                    n_pop    = '0;
                    n_status = bmh_pkg::ST_OK;
                    n_pos    = '0;
                    case (i_job.kind)
                        bmh_pkg::K_PUSH: begin
                            n_pos   = bmh_pkg::ADDR_W'(i_job.count - bmh_pkg::CNT_W'(1));
                            n_state = S_UP_RD;
                        end
                        bmh_pkg::K_POP: begin
                            n_state = S_POP_RD;
                        end
                        bmh_pkg::K_EMPTY: begin
                            n_status = bmh_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_status = bmh_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (r_rd0 >= r_v) begin
                    n_state = S_DONE;
                end else begin
                    w_wd    = r_rd0;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end
            end
            S_POP_RD: begin
                w_ra0   = '0;
                n_state = S_POP_LD;
            end
            S_POP_LD: begin
                n_pop   = r_rd0;
                n_v     = r_rd1;
                n_pos   = '0;
                n_state = (r_n == '0) ? S_DONE : S_DN_RD;
            end
            S_DN_RD: begin
                w_ra0 = w_lc[bmh_pkg::ADDR_W-1:0];
                w_ra1 = w_rc[bmh_pkg::ADDR_W-1:0];
                if (w_lc >= w_n_ch) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_r_gt) begin
                    w_wd    = r_rd1;
                    n_pos   = w_rc[bmh_pkg::ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else if (w_l_gt) begin
                    w_wd    = r_rd0;
                    n_pos   = w_lc[bmh_pkg::ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd0 <= r_mem[w_ra0];
        r_rd1 <= r_mem[w_ra1];
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_pos    <= n_pos;
        r_n      <= n_n;
        r_pop    <= n_pop;
        r_status <= n_status;
        if (w_load) begin
            r_out_pop    <= r_pop;
            r_out_status <= r_status;
            r_out_count  <= bmh_pkg::ENTRY_W'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### src/binary_max_heap_top.sv
// binary_max_heap_top: push/pop max-heap priority queue, front classifier, job queue, heap engine
// the heap engine takes one command at a time and finishes it before it takes the next;
// the read-then-compare loop on the entry memory, once per tree level, sets its pace
// errors (pop on empty, push on full) go straight to the done state and leave the heap as it was
// reset clears the entry count, queue, sequencer and result valid flag; memory contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bmh_cmd_if.sink     i_cmd,
    bmh_rsp_if.source   o_rsp
);

    bmh_pkg::t_job w_f_job;
    logic          w_f_valid;
    logic          w_f_ready;
    bmh_pkg::t_job w_b_job;
    logic          w_b_valid;
    logic          w_b_ready;

    bmh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_job       (w_f_job),
        .o_job_valid (w_f_valid),
        .i_job_ready (w_f_ready)
    );

    bmh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_f_job),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_job   (w_b_job),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready)
    );

    bmh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_b_job),
        .i_job_valid (w_b_valid),
        .o_job_ready (w_b_ready),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

### src/bmh_checker.sv
// bmh_checker: port-level assertions on the heap response channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bmh_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_rsp_valid,
    input wire logic                               i_rsp_ready,
    input wire logic signed [bmh_pkg::VALUE_W-1:0] i_rsp_popped_value,
    input wire logic [bmh_pkg::STATUS_W-1:0]       i_rsp_status,
    input wire logic [bmh_pkg::ENTRY_W-1:0]        i_rsp_entry_count
);

    // stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_popped_value)
            && $stable(i_rsp_status) && $stable(i_rsp_entry_count))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status <= bmh_pkg::ST_FULL)
        else $error("undefined status code");

    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bmh_pkg::ST_OK |-> i_rsp_popped_value == '0)
        else $error("failed command carries a popped value");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == bmh_pkg::ST_FULL
            |-> i_rsp_entry_count == bmh_pkg::ENTRY_W'(bmh_pkg::HEAP_DEPTH))
        else $error("full status with heap not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == bmh_pkg::ST_EMPTY |-> i_rsp_entry_count == '0)
        else $error("empty status with entries held");

endmodule

bind binary_max_heap_top bmh_checker u_bmh_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_popped_value (o_rsp.popped_value),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_entry_count  (o_rsp.entry_count)
);
`default_nettype wire

### tb/tb_binary_max_heap_top.sv
// tb_binary_max_heap_top: self-checking testbench of the max-heap priority queue
`timescale 1ns / 1ps
module tb_binary_max_heap_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 60;
    localparam int DEEP_PUSHES = 100;
    localparam int MIX_ITEMS   = 110;

    typedef struct packed {
        logic signed [bmh_pkg::VALUE_W-1:0] popped;
        logic [bmh_pkg::STATUS_W-1:0]       status;
        logic [bmh_pkg::ENTRY_W-1:0]        count;
    } t_heap_result;

    logic i_clk;
    logic i_rst_n;

    bmh_cmd_if cmd_if();
    bmh_rsp_if rsp_if();

    binary_max_heap_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // shadow heap, updated at each accepted command transfer
    logic signed [bmh_pkg::VALUE_W-1:0] heap_mem [bmh_pkg::HEAP_DEPTH];
    int                                 heap_size;
    t_heap_result                       pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_count;
    int cycle_count;
    int n_push;
    int n_pop;
    int n_full;
    int n_empty;
    int peak_size;
    t_heap_result chk_want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb_binary_max_heap_top: done, errors");
            $finish;
        end
    end

    function automatic t_heap_result heap_apply(input logic cmd,
                                                input logic signed [bmh_pkg::VALUE_W-1:0] val);
        t_heap_result r;
        int pos;
        int parent;
        int lc;
        int rc;
        int best;
        logic signed [bmh_pkg::VALUE_W-1:0] t;
        r.popped = '0;
        r.status = bmh_pkg::ST_OK;
        if (cmd == bmh_pkg::CMD_PUSH) begin
            if (heap_size >= bmh_pkg::HEAP_DEPTH) begin
                r.status = bmh_pkg::ST_FULL;
            end else begin
                pos = heap_size;
                heap_mem[pos] = val;
                heap_size++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_mem[parent] >= heap_mem[pos]) break;
                    t = heap_mem[parent];
                    heap_mem[parent] = heap_mem[pos];
                    heap_mem[pos] = t;
                    pos = parent;
                end
            end
        end else if (heap_size == 0) begin
            r.status = bmh_pkg::ST_EMPTY;
        end else begin
            r.popped = heap_mem[0];
            heap_size--;
            heap_mem[0] = heap_mem[heap_size];
            pos = 0;
            // strict compares keep the left child on ties
            forever begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                best = pos;
                if (lc < heap_size && heap_mem[lc] > heap_mem[best]) best = lc;
                if (rc < heap_size && heap_mem[rc] > heap_mem[best]) best = rc;
                if (best == pos) break;
                t = heap_mem[pos];
                heap_mem[pos] = heap_mem[best];
                heap_mem[best] = t;
                pos = best;
            end
        end
        r.count = bmh_pkg::ENTRY_W'(heap_size);
        return r;
    endfunction

    function automatic logic signed [bmh_pkg::VALUE_W-1:0] rand_value();
        logic signed [bmh_pkg::VALUE_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = int'($urandom_range(16)) - 8;
            7: begin
                case ($urandom_range(3))
                    0:       v = {1'b0, {(bmh_pkg::VALUE_W-1){1'b1}}};
                    1:       v = {1'b1, {(bmh_pkg::VALUE_W-1){1'b0}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default:    v = int'($urandom_range(2000)) - 1000;
        endcase
        return v;
    endfunction

    task automatic send_cmd(input logic cmd, input logic signed [bmh_pkg::VALUE_W-1:0] val);
        t_heap_result exp_r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.value   <= val;
        do @(posedge i_clk); while (!cmd_if.ready);
        exp_r = heap_apply(cmd, val);
        pending_results.push_back(exp_r);
        if (exp_r.status == bmh_pkg::ST_FULL) n_full++;
        else if (exp_r.status == bmh_pkg::ST_EMPTY) n_empty++;
        else if (cmd == bmh_pkg::CMD_PUSH) n_push++;
        else n_pop++;
        if (heap_size > peak_size) peak_size = heap_size;
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: expected no result, got popped=%0d status=%0d count=%0d",
                         $time, rsp_if.popped_value, rsp_if.status, rsp_if.entry_count);
            end else begin
                chk_want = pending_results.pop_front();
                if (rsp_if.popped_value !== chk_want.popped ||
                    rsp_if.status !== chk_want.status ||
                    rsp_if.entry_count !== chk_want.count) begin
                    err_count++;
                    $display("%0t: mismatch expected popped=%0d status=%0d count=%0d,",
                             $time, chk_want.popped, chk_want.status, chk_want.count);
                    $display("    got popped=%0d status=%0d count=%0d",
                             rsp_if.popped_value, rsp_if.status, rsp_if.entry_count);
                end
            end
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_cmd(bmh_pkg::CMD_POP, '0);
        send_cmd(bmh_pkg::CMD_POP, $urandom);
        send_cmd(bmh_pkg::CMD_PUSH, {1'b1, {(bmh_pkg::VALUE_W-1){1'b0}}});
        send_cmd(bmh_pkg::CMD_PUSH, {1'b0, {(bmh_pkg::VALUE_W-1){1'b1}}});
        send_cmd(bmh_pkg::CMD_PUSH, '0);
        send_cmd(bmh_pkg::CMD_PUSH, '1);
        // equal siblings and equal parent exercise the tie rules
        send_cmd(bmh_pkg::CMD_PUSH, 32'sd5);
        send_cmd(bmh_pkg::CMD_PUSH, 32'sd5);
        send_cmd(bmh_pkg::CMD_PUSH, 32'sd5);
        send_cmd(bmh_pkg::CMD_PUSH, 32'sd1);
        send_cmd(bmh_pkg::CMD_PUSH, {1'b0, {(bmh_pkg::VALUE_W-1){1'b1}}});
        repeat (10) send_cmd(bmh_pkg::CMD_POP, $urandom);
        wait_drained();
    endtask

    task automatic test_deep_heap();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DEEP_PUSHES) send_cmd(bmh_pkg::CMD_PUSH, rand_value());
        // draining the heap checks the whole order over several tree levels
        while (heap_size > 0) send_cmd(bmh_pkg::CMD_POP, $urandom);
        send_cmd(bmh_pkg::CMD_POP, '0);
        wait_drained();
    endtask

    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        int target;
        int k;
        logic cmd;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = 0;
        for (k = 0; k < n_items; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(19))
                    0:          target = $urandom_range(400, 81);
                    1, 2, 3, 4: target = $urandom_range(80, 13);
                    default:    target = $urandom_range(12);
                endcase
            end
            if (heap_size < target) begin
                cmd = ($urandom_range(99) < 80) ? bmh_pkg::CMD_PUSH : bmh_pkg::CMD_POP;
            end else begin
                cmd = ($urandom_range(99) < 80) ? bmh_pkg::CMD_POP : bmh_pkg::CMD_PUSH;
            end
            send_cmd(cmd, rand_value());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = bmh_pkg::CMD_PUSH;
        cmd_if.value   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        heap_size      = 0;
        err_count      = 0;
        cycle_count    = 0;
        n_push         = 0;
        n_pop          = 0;
        n_full         = 0;
        n_empty        = 0;
        peak_size      = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_deep_heap();
        test_random_mix(MIX_ITEMS, 0, 0);
        test_random_mix(MIX_ITEMS, 68, 0);
        test_random_mix(MIX_ITEMS, 0, 68);
        test_random_mix(MIX_ITEMS, 33, 33);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d pushes, %0d pops, %0d full rejects, %0d empty rejects",
                 n_push, n_pop, n_full, n_empty);
        $display("peak heap size %0d, %0d cycles, %0d mismatches",
                 peak_size, cycle_count, err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb_binary_max_heap_top: done, clean");
        end else begin
            $display("tb_binary_max_heap_top: done, errors");
        end
        $finish;
    end

endmodule
